// File: rtl/ces_pkg.sv
// ----------------------------------------------------------------------------
// ces_pkg
// Shared widths, constants, control word types and the microcode table of the
// cubic easing setpoint smoother.
// ----------------------------------------------------------------------------
package ces_pkg;

  localparam int FRAC_BITS = 16;

  // register and field widths
  localparam int INC_W  = 17;                 // time increment register
  localparam int TW     = FRAC_BITS + 1;      // blend time, 0 .. 1.0
  localparam int SUMW   = ((TW > INC_W) ? TW : INC_W) + 1;
  localparam int WW     = FRAC_BITS + 5;      // hermite weights, signed
  localparam int DW     = 33;                 // goal minus start, signed
  localparam int PW     = WW + DW;            // multiplier product
  localparam int AW     = PW + 1;             // accumulator
  localparam int RW     = AW - FRAC_BITS;     // rounded accumulator
  localparam int SW     = RW + 1;             // rounded sum plus start

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [TW-1:0]        ONE_T     = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [INC_W-1:0]     INC_RESET = INC_W'(1092);
  localparam logic signed [WW-1:0] ONE_W     = WW'(ONE_T);
  localparam logic signed [AW-1:0] HALF_A    = AW'(ONE_T >> 1);
  localparam logic signed [SW-1:0] SAT_MAX   = SW'(32'sh7fff_ffff);
  localparam logic signed [SW-1:0] SAT_MIN   = SW'(-32'sh7fff_ffff - 32'sd1);

  // register index within the configuration space
  localparam logic [ADDR_W-3:0] REG_TIME_INCREMENT = '0;

  // microprogram
  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_ENTRY = step_t'(0);
  localparam step_t STEP_TT    = step_t'(1);
  localparam step_t STEP_T2    = step_t'(2);
  localparam step_t STEP_T2T   = step_t'(3);
  localparam step_t STEP_T3    = step_t'(4);
  localparam step_t STEP_W1D   = step_t'(5);
  localparam step_t STEP_W2V   = step_t'(6);
  localparam step_t STEP_Q1D   = step_t'(7);
  localparam step_t STEP_Q2V   = step_t'(8);
  localparam step_t STEP_VSUM  = step_t'(9);
  localparam step_t STEP_FIN   = step_t'(10);
  localparam step_t LAST_STEP  = STEP_FIN;

  typedef enum logic [2:0] {
    A_T, A_T2, A_W1, A_W2, A_Q1, A_Q2
  } a_sel_t;

  typedef enum logic [1:0] {
    B_T, B_D, B_V
  } b_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD, ACC_LOAD, ACC_ADD
  } acc_op_t;

  typedef struct packed {
    a_sel_t  a_sel;
    b_sel_t  b_sel;
    acc_op_t acc_op;
    logic    wr_t2;
    logic    wr_t3;
    logic    wr_pos;
    logic    adv;      // advance blend time unless a retarget is pending
    logic    fin;      // last step of an evaluation
    logic    jmp_en;   // on fin, jump when a retarget is pending
    step_t   jmp_to;
  } ctrl_t;

  typedef struct packed {
    ctrl_t uop;
    logic  load;
    logic  adv;
    logic  commit;
    logic  emit;
  } dp_ctl_t;

  function automatic ctrl_t ucode(input step_t step);
    ctrl_t c;
    c = '0;
    unique case (step)
      STEP_ENTRY: c.adv = 1'b1;
      STEP_TT: begin
        c.a_sel = A_T;
        c.b_sel = B_T;
      end
      STEP_T2:    c.wr_t2 = 1'b1;
      STEP_T2T: begin
        c.a_sel = A_T2;
        c.b_sel = B_T;
      end
      STEP_T3:    c.wr_t3 = 1'b1;
      STEP_W1D: begin
        c.a_sel = A_W1;
        c.b_sel = B_D;
      end
      STEP_W2V: begin
        c.a_sel  = A_W2;
        c.b_sel  = B_V;
        c.acc_op = ACC_LOAD;
      end
      STEP_Q1D: begin
        c.a_sel  = A_Q1;
        c.b_sel  = B_D;
        c.acc_op = ACC_ADD;
      end
      STEP_Q2V: begin
        c.a_sel  = A_Q2;
        c.b_sel  = B_V;
        c.acc_op = ACC_LOAD;
        c.wr_pos = 1'b1;
      end
      STEP_VSUM:  c.acc_op = ACC_ADD;
      STEP_FIN: begin
        c.fin    = 1'b1;
        c.jmp_en = 1'b1;
        c.jmp_to = STEP_TT;
      end
      default:    c = '0;
    endcase
    return c;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] x);
    logic signed [31:0] r;
    if (x > SAT_MAX) begin
      r = 32'sh7fff_ffff;
    end else if (x < SAT_MIN) begin
      r = -32'sh7fff_ffff - 32'sd1;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/ces_if.sv
// ----------------------------------------------------------------------------
// ces channel interfaces
// Valid/ready channels for the tick word and the result word.
// ----------------------------------------------------------------------------
interface ces_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic signed [31:0] new_goal;

  modport source (output valid, output func, output new_goal, input ready);
  modport sink   (input valid, input func, input new_goal, output ready);
endinterface

interface ces_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] position;
  logic signed [31:0] velocity;

  modport source (output valid, output position, output velocity, input ready);
  modport sink   (input valid, input position, input velocity, output ready);
endinterface

// File: rtl/ces_cfg.sv
// ----------------------------------------------------------------------------
// ces_cfg
// APB register file holding the blend time increment.
// ----------------------------------------------------------------------------
module ces_cfg import ces_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output logic [INC_W-1:0]  time_inc
);

  logic [INC_W-1:0] inc_r;
  logic [INC_W-1:0] inc_nxt;
  logic             hit;

  // low two address bits are the byte lane
  assign hit    = (paddr[ADDR_W-1:2] == REG_TIME_INCREMENT);
  assign pready = 1'b1;

  always_comb begin
    inc_nxt = inc_r;
    if (psel && penable && pwrite && hit) begin
      inc_nxt = pwdata[INC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inc_r <= INC_RESET;
    end else begin
      inc_r <= inc_nxt;
    end
  end

  assign prdata   = hit ? {{(DATA_W-INC_W){1'b0}}, inc_r} : '0;
  assign time_inc = inc_r;

endmodule

// File: rtl/ces_seq.sv
// ----------------------------------------------------------------------------
// ces_seq
// Microcode sequencer: step counter, control store, retarget jump and the
// handshake of both channels.
// ----------------------------------------------------------------------------
module ces_seq import ces_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  logic    retgt,
  output dp_ctl_t ctl
);

  step_t step_r, step_nxt;
  logic  busy_r, busy_nxt;
  logic  out_valid_r, out_valid_nxt;
  ctrl_t uop;
  logic  accept;
  logic  jump;
  logic  finish;
  logic  emit;

  always_comb begin
    uop    = ucode(step_r);
    accept = in_valid && !busy_r;
    jump   = busy_r && uop.fin && uop.jmp_en && retgt;
    finish = busy_r && uop.fin && !(uop.jmp_en && retgt);
    // result register frees up in the same cycle it is taken
    emit   = finish && (!out_valid_r || out_ready);

    step_nxt = step_r;
    busy_nxt = busy_r;
    priority if (!busy_r) begin
      busy_nxt = accept;
      step_nxt = STEP_ENTRY;
    end else if (jump) begin
      step_nxt = uop.jmp_to;
    end else if (emit) begin
      busy_nxt = 1'b0;
      step_nxt = STEP_ENTRY;
    end else if (!uop.fin) begin
      step_nxt = step_t'(step_r + 1'b1);
    end else begin
      // result register still full, hold on the last step
      step_nxt = step_r;
    end

    out_valid_nxt = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

    ctl.uop    = uop;
    ctl.load   = accept;
    ctl.commit = jump;
    ctl.adv    = (busy_r && uop.adv && !retgt) || jump;
    ctl.emit   = emit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= STEP_ENTRY;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = !busy_r;
  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_idle_at_entry: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> step_r == STEP_ENTRY)
    else $error("ces_seq: idle with step counter off entry");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy_r && step_r == STEP_ENTRY)
    else $error("ces_seq: accepted word did not start the program");

  a_emit_presents: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_valid_r && !busy_r)
    else $error("ces_seq: result not presented after emit");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= LAST_STEP)
    else $error("ces_seq: step counter beyond program");
`endif

endmodule

// File: rtl/ces_dp.sv
// ----------------------------------------------------------------------------
// ces_dp
// Datapath: curve state, one shared signed multiplier, accumulator,
// rounding and saturation, result register.
// ----------------------------------------------------------------------------
module ces_dp import ces_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  dp_ctl_t            ctl,
  input  logic [INC_W-1:0]   time_inc,
  input  logic               in_func,
  input  logic signed [31:0] in_new_goal,
  output logic               retgt,
  output logic signed [31:0] out_position,
  output logic signed [31:0] out_velocity
);

  // control state
  logic [TW-1:0]      blend_r, blend_nxt;
  logic signed [31:0] start_pos_r, start_pos_nxt;
  logic signed [31:0] start_vel_r, start_vel_nxt;
  logic signed [31:0] goal_r, goal_nxt;
  logic               retgt_r, retgt_nxt;

  // working registers
  logic signed [31:0] new_goal_r;
  logic [TW-1:0]      t2_r;
  logic [TW-1:0]      t3_r;
  logic signed [PW-1:0] prod_r;
  logic signed [AW-1:0] acc_r, acc_nxt;
  logic signed [31:0] pos_r;
  logic signed [31:0] out_pos_r;
  logic signed [31:0] out_vel_r;

  logic [TW-1:0]        base;
  logic [SUMW-1:0]      bsum;
  logic signed [WW-1:0] t_s, t2_s, t3_s;
  logic signed [WW-1:0] w1, w2, q1, q2;
  logic signed [WW-1:0] a_op;
  logic signed [DW-1:0] b_op;
  logic signed [DW-1:0] diff;
  logic signed [PW-1:0] prod_nxt;
  logic signed [AW-1:0] prod_h;
  logic signed [AW-1:0] acc_h;
  logic signed [RW-1:0] rnd_acc;
  logic signed [SW-1:0] pos_sum;
  logic signed [31:0]   pos_sat;
  logic signed [31:0]   vel_sat;

  // blend time advance, clamped at 1.0; restarts from zero on a retarget
  assign base = ctl.commit ? '0 : blend_r;
  assign bsum = SUMW'(base) + SUMW'(time_inc);
  assign blend_nxt = ctl.adv ? ((bsum > SUMW'(ONE_T)) ? ONE_T : bsum[TW-1:0]) : blend_r;

  assign t_s  = $signed({{(WW-TW){1'b0}}, blend_r});
  assign t2_s = $signed({{(WW-TW){1'b0}}, t2_r});
  assign t3_s = $signed({{(WW-TW){1'b0}}, t3_r});

  assign w1 = WW'(3 * t2_s - 2 * t3_s);
  assign w2 = WW'(t3_s - 2 * t2_s + t_s);
  assign q1 = WW'(6 * t_s - 6 * t2_s);
  assign q2 = WW'(3 * t2_s - 4 * t_s + ONE_W);

  assign diff = $signed({goal_r[31], goal_r}) - $signed({start_pos_r[31], start_pos_r});

  always_comb begin
    unique case (ctl.uop.a_sel)
      A_T:     a_op = t_s;
      A_T2:    a_op = t2_s;
      A_W1:    a_op = w1;
      A_W2:    a_op = w2;
      A_Q1:    a_op = q1;
      A_Q2:    a_op = q2;
      default: a_op = t_s;
    endcase
    unique case (ctl.uop.b_sel)
      B_T:     b_op = $signed({{(DW-TW){1'b0}}, blend_r});
      B_D:     b_op = diff;
      B_V:     b_op = DW'(start_vel_r);
      default: b_op = $signed({{(DW-TW){1'b0}}, blend_r});
    endcase
  end

  assign prod_nxt = a_op * b_op;

  always_comb begin
    unique case (ctl.uop.acc_op)
      ACC_HOLD: acc_nxt = acc_r;
      ACC_LOAD: acc_nxt = AW'(prod_r);
      ACC_ADD:  acc_nxt = acc_r + AW'(prod_r);
      default:  acc_nxt = acc_r;
    endcase
  end

  // round half up: add one half, then floor
  assign prod_h  = AW'(prod_r) + HALF_A;
  assign acc_h   = acc_r + HALF_A;
  assign rnd_acc = $signed(acc_h[AW-1:FRAC_BITS]);
  assign pos_sum = SW'(start_pos_r) + SW'(rnd_acc);
  assign pos_sat = sat32(pos_sum);
  assign vel_sat = sat32(SW'(rnd_acc));

  always_comb begin
    start_pos_nxt = start_pos_r;
    start_vel_nxt = start_vel_r;
    goal_nxt      = goal_r;
    retgt_nxt     = retgt_r;
    if (ctl.load) begin
      retgt_nxt = in_func && (in_new_goal != goal_r);
    end else if (ctl.commit) begin
      start_pos_nxt = pos_r;
      start_vel_nxt = vel_sat;
      goal_nxt      = new_goal_r;
      retgt_nxt     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blend_r     <= '0;
      start_pos_r <= '0;
      start_vel_r <= '0;
      goal_r      <= '0;
      retgt_r     <= 1'b0;
    end else begin
      blend_r     <= blend_nxt;
      start_pos_r <= start_pos_nxt;
      start_vel_r <= start_vel_nxt;
      goal_r      <= goal_nxt;
      retgt_r     <= retgt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    if (ctl.load) begin
      new_goal_r <= in_new_goal;
    end
    if (ctl.uop.wr_t2) begin
      t2_r <= prod_h[FRAC_BITS+TW-1:FRAC_BITS];
    end
    if (ctl.uop.wr_t3) begin
      t3_r <= prod_h[FRAC_BITS+TW-1:FRAC_BITS];
    end
    if (ctl.uop.wr_pos) begin
      pos_r <= pos_sat;
    end
    if (ctl.emit) begin
      out_pos_r <= pos_r;
      out_vel_r <= vel_sat;
    end
  end

  assign retgt        = retgt_r;
  assign out_position = out_pos_r;
  assign out_velocity = out_vel_r;

`ifndef SYNTHESIS
  a_blend_range: assert property (@(posedge clk) disable iff (!rst_n)
    blend_r <= ONE_T)
    else $error("ces_dp: blend time above one");
`endif

endmodule

// File: rtl/cubic_easing_setpoint_smoother.sv
// ----------------------------------------------------------------------------
// cubic_easing_setpoint_smoother
// Cubic Hermite easing of a setpoint toward a goal, Q16.16, one result word
// per tick word.
// ----------------------------------------------------------------------------
// Each tick word runs an 11-step microprogram on one shared signed multiplier
// (t^2, t^3, then the two weighted sums for position and velocity); a new
// tick word is taken only once the last one has reached the result register.
// A tick that retargets to a different goal first runs the program at the
// old blend time to capture the new start point and then runs it again. The
// result register lets the next tick word be taken while a result waits on a
// stalled output. The blend time increment sits at byte address 0 of the APB
// port and must only be written while the block is idle.
module cubic_easing_setpoint_smoother import ces_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  ces_in_if.sink            in_ch,
  ces_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [INC_W-1:0] time_inc;
  logic             retgt;
  dp_ctl_t          ctl;

  ces_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .time_inc (time_inc)
  );

  ces_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .retgt     (retgt),
    .ctl       (ctl)
  );

  ces_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl),
    .time_inc     (time_inc),
    .in_func      (in_ch.func),
    .in_new_goal  (in_ch.new_goal),
    .retgt        (retgt),
    .out_position (out_ch.position),
    .out_velocity (out_ch.velocity)
  );

endmodule
